/* hdl/bb3_pkg.sv */
`default_nettype none

package bb3_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;

  localparam int unsigned DimW   = 11;
  localparam int unsigned ColW   = $clog2(MaxWidth);
  localparam int unsigned RowW   = $clog2(MaxHeight);
  localparam int unsigned PixW   = 8;
  localparam int unsigned ColSumW = PixW + 2;
  localparam int unsigned SumW   = PixW + 4;

  // Multiply by ceil(2^16 / 9) and shift: exact for every sum up to 2295.
  localparam int unsigned RecipShift = 16;
  localparam int unsigned RecipW     = 13;
  localparam logic [RecipW-1:0] RecipNine = RecipW'(((1 << RecipShift) + 8) / 9);
  localparam int unsigned ProdW = SumW + RecipW;

  localparam logic [DimW-1:0] MinDim      = DimW'(3);
  localparam logic [DimW-1:0] MaxWidthV   = DimW'(MaxWidth);
  localparam logic [DimW-1:0] MaxHeightV  = DimW'(MaxHeight);
  localparam logic [DimW-1:0] ResetWidth  = DimW'(640);
  localparam logic [DimW-1:0] ResetHeight = DimW'(480);

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic                  wr_en;
    logic [ColW-1:0]       wr_addr;
    logic [2*PixW-1:0]     wr_data;
    logic [ColW-1:0]       rd_addr;
  } ram_req_t;

endpackage

`default_nettype wire

/* hdl/bb3_line_ram.sv */
`default_nettype none

module bb3_line_ram (
  input  wire logic                         clk_i,
  input  wire bb3_pkg::ram_req_t            req_i,
  output logic [2*bb3_pkg::PixW-1:0]        rd_data_o
);

  logic [2*bb3_pkg::PixW-1:0] mem_q [bb3_pkg::MaxWidth];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[req_i.rd_addr];
  end

endmodule

`default_nettype wire

/* hdl/box_blur_3x3.sv */
// 3x3 box mean over a raster-order 8-bit grayscale stream.
// Pixels enter on the in channel (in_valid_i / in_ready_o, pixel_i), one
// request per pixel, row by row. Results leave on the out channel
// (out_valid_o / out_ready_i) only for pixels that close a full 3x3 window,
// so a frame of W x H pixels yields (W-2) x (H-2) results; row_end_o marks
// the last result of an output row and frame_end_o the last of the frame.
// Width and height are set through the write port and are clamped to 3..1024;
// change them only while the block is idle. Counters wrap, so the next
// frame may follow without a gap.
// Throughput is one pixel per cycle while the receiver keeps up. After its
// pixel is accepted, a result is registered first with the window sum, then
// with the mean. The two stored rows share one 1024 x 16 RAM whose read is
// issued ahead for the next column. When the receiver stalls, the result
// waits in the output register and pixels keep coming in until one that
// closes a window reaches the sum stage, then in_ready_o drops. Reset clears
// the counters, the pipeline and the registers to 640 x 480; the RAM is not
// cleared and needs no clearing.
`default_nettype none

module box_blur_3x3 (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [0:0]                  cfg_index_i,
  input  wire logic [bb3_pkg::DimW-1:0]    cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [bb3_pkg::PixW-1:0]    pixel_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [bb3_pkg::PixW-1:0]         mean_value_o,
  output logic                             row_end_o,
  output logic                             frame_end_o
);

  logic [bb3_pkg::DimW-1:0] width_q, height_q;
  logic [bb3_pkg::DimW-1:0] width_eff, height_eff;
  logic [bb3_pkg::ColW-1:0] col_q, col_d;
  logic [bb3_pkg::RowW-1:0] row_q, row_d;
  logic last_col, last_row, produce, accept, advance;

  logic [2*bb3_pkg::PixW-1:0] rd_data;
  logic [bb3_pkg::PixW-1:0]   top_pix, mid_pix;
  bb3_pkg::ram_req_t          ram_req;

  logic [bb3_pkg::ColSumW-1:0] col_sum, cs1_q, cs2_q;
  logic [bb3_pkg::SumW-1:0]    win_sum;

  logic                     s1_valid_q, s1_row_end_q, s1_frame_end_q;
  logic [bb3_pkg::SumW-1:0] s1_sum_q;
  logic [bb3_pkg::ProdW-1:0] product;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bb3_pkg::ResetWidth;
      height_q <= bb3_pkg::ResetHeight;
    end else if (cfg_we_i) begin
      unique case (bb3_pkg::cfg_reg_e'(cfg_index_i))
        bb3_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        bb3_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < bb3_pkg::MinDim) begin
      width_eff = bb3_pkg::MinDim;
    end else if (width_q > bb3_pkg::MaxWidthV) begin
      width_eff = bb3_pkg::MaxWidthV;
    end else begin
      width_eff = width_q;
    end
    if (height_q < bb3_pkg::MinDim) begin
      height_eff = bb3_pkg::MinDim;
    end else if (height_q > bb3_pkg::MaxHeightV) begin
      height_eff = bb3_pkg::MaxHeightV;
    end else begin
      height_eff = height_q;
    end
  end

  assign last_col = (bb3_pkg::DimW'(col_q) >= (width_eff - bb3_pkg::DimW'(1)));
  assign last_row = (bb3_pkg::DimW'(row_q) >= (height_eff - bb3_pkg::DimW'(1)));
  assign produce  = (row_q >= bb3_pkg::RowW'(2)) && (col_q >= bb3_pkg::ColW'(2));

  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + bb3_pkg::RowW'(1);
      end else begin
        col_d = col_q + bb3_pkg::ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // The read address runs one column ahead, so the stored pixels of the
  // current column are already registered when its pixel arrives.
  assign top_pix = rd_data[2*bb3_pkg::PixW-1:bb3_pkg::PixW];
  assign mid_pix = rd_data[bb3_pkg::PixW-1:0];

  always_comb begin
    ram_req.wr_en   = accept;
    ram_req.wr_addr = col_q;
    ram_req.wr_data = {mid_pix, pixel_i};
    ram_req.rd_addr = col_d;
  end

  bb3_line_ram u_line_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (rd_data)
  );

  assign col_sum = bb3_pkg::ColSumW'(top_pix) + bb3_pkg::ColSumW'(mid_pix)
                 + bb3_pkg::ColSumW'(pixel_i);
  assign win_sum = bb3_pkg::SumW'(col_sum) + bb3_pkg::SumW'(cs1_q)
                 + bb3_pkg::SumW'(cs2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs1_q <= '0;
      cs2_q <= '0;
    end else if (accept) begin
      cs1_q <= col_sum;
      cs2_q <= cs1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= accept && produce;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sum_q       <= win_sum;
      s1_row_end_q   <= last_col;
      s1_frame_end_q <= last_col && last_row;
    end
  end

  assign product = bb3_pkg::ProdW'(s1_sum_q) * bb3_pkg::ProdW'(bb3_pkg::RecipNine);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      mean_value_o <= product[bb3_pkg::RecipShift +: bb3_pkg::PixW];
      row_end_o    <= s1_row_end_q;
      frame_end_o  <= s1_frame_end_q;
    end
  end

endmodule

`default_nettype wire

/* hdl/bb3_checker.sv */
`default_nettype none

module bb3_checker (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_ready_o,
  input wire logic                     out_valid_o,
  input wire logic                     out_ready_i,
  input wire logic [bb3_pkg::PixW-1:0] mean_value_o,
  input wire logic                     row_end_o,
  input wire logic                     frame_end_o
);

  logic in_req;
  assign in_req = in_valid_i && in_ready_o;

  // The end of a frame is always the end of an output row.
  a_frame_end_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> row_end_o)
    else $error("frame_end without row_end");

  // A receiver that is ready never blocks the input side.
  a_ready_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output is ready");

  // A result needs an accepted request that passed the sum register, or a held result.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(in_req, 2) && !$past(out_valid_o) |-> !out_valid_o)
    else $error("result without a request");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(mean_value_o))
    else $error("stalled result changed");

endmodule

bind box_blur_3x3 bb3_checker u_bb3_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .mean_value_o (mean_value_o),
  .row_end_o    (row_end_o),
  .frame_end_o  (frame_end_o)
);

`default_nettype wire

/* tb/box_blur_3x3_monitor.sv */
`timescale 1ns / 100ps

module box_blur_3x3_monitor
  import bb3_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [0:0]      cfg_index_i,
  input  logic [DimW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  logic [PixW-1:0] pixel_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  logic [PixW-1:0] mean_value_i,
  input  logic            row_end_i,
  input  logic            frame_end_i,
  output int              pending_o,
  output int              errors_o
);

  localparam int unsigned WindowArea = 9;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic [PixW-1:0] mean_value;
    logic            row_end;
    logic            frame_end;
  } blur_result_t;

  logic [DimW-1:0] width_reg;
  logic [DimW-1:0] height_reg;
  logic [PixW-1:0] upper_row [MaxWidth];
  logic [PixW-1:0] middle_row [MaxWidth];
  logic [PixW-1:0] window_px [6];
  int unsigned     col_pos;
  int unsigned     row_pos;
  blur_result_t    mean_queue [$];
  int              mismatch_count;

  function automatic int unsigned clamp_dim(logic [DimW-1:0] v, int unsigned limit);
    if (v < MinDim) return 32'(MinDim);
    if (v > limit) return limit;
    return 32'(v);
  endfunction

  task automatic blur_pixel(input logic [PixW-1:0] px);
    int unsigned     w;
    int unsigned     h;
    int unsigned     idx;
    int unsigned     sum;
    logic [PixW-1:0] top_px;
    logic [PixW-1:0] mid_px;
    bit              last_col;
    bit              last_row;
    blur_result_t    res;
    w = clamp_dim(width_reg, MaxWidth);
    h = clamp_dim(height_reg, MaxHeight);
    idx = (col_pos < MaxWidth) ? col_pos : MaxWidth - 1;
    top_px = upper_row[idx];
    mid_px = middle_row[idx];
    last_col = (col_pos >= w - 1);
    last_row = (row_pos >= h - 1);
    if (row_pos >= 2 && col_pos >= 2) begin
      sum = 32'(top_px) + 32'(mid_px) + 32'(px);
      for (int k = 0; k < 6; k++) sum += 32'(window_px[k]);
      res.mean_value = PixW'(sum / WindowArea);
      res.row_end = last_col;
      res.frame_end = last_col && last_row;
      mean_queue = {mean_queue, res};
    end
    upper_row[idx] = mid_px;
    middle_row[idx] = px;
    window_px[0] = window_px[3];
    window_px[1] = window_px[4];
    window_px[2] = window_px[5];
    window_px[3] = top_px;
    window_px[4] = mid_px;
    window_px[5] = px;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  task automatic check_result();
    blur_result_t got;
    blur_result_t want;
    got.mean_value = mean_value_i;
    got.row_end = row_end_i;
    got.frame_end = frame_end_i;
    if (mean_queue.size() == 0) begin
      if (mismatch_count < ReportLimit) begin
        $display("%0t: result with none pending: mean %0d row_end %b frame_end %b",
                 $realtime, got.mean_value, got.row_end, got.frame_end);
      end
      mismatch_count++;
    end else begin
      want = mean_queue.pop_front();
      if (got.mean_value !== want.mean_value || got.row_end !== want.row_end ||
          got.frame_end !== want.frame_end) begin
        if (mismatch_count < ReportLimit) begin
          $display("%0t: mean %0d/%0d row_end %b/%b frame_end %b/%b (want/got)",
                   $realtime, want.mean_value, got.mean_value, want.row_end,
                   got.row_end, want.frame_end, got.frame_end);
        end
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg = ResetWidth;
      height_reg = ResetHeight;
      for (int k = 0; k < 6; k++) window_px[k] = '0;
      col_pos = 0;
      row_pos = 0;
      mean_queue.delete();
      mismatch_count = 0;
      pending_o <= 0;
      errors_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_IMAGE_WIDTH: width_reg = cfg_data_i;
          REG_IMAGE_HEIGHT: height_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) blur_pixel(pixel_i);
      if (out_valid_i && out_ready_i) check_result();
      pending_o <= mean_queue.size();
      errors_o <= mismatch_count;
    end
  end

endmodule

/* tb/tb_box_blur_3x3.sv */
`timescale 1ns / 100ps

module tb_box_blur_3x3;
  import bb3_pkg::*;

  localparam int RandomPixels = 1080;
  localparam int StallLimit = 5000;
  localparam int SettleCycles = 6;

  typedef enum int {
    PAT_RANDOM,
    PAT_EXTREME,
    PAT_BRIGHT,
    PAT_FLAT,
    PAT_DARK
  } pixel_pattern_e;

  logic            clk_i;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [0:0]      cfg_index_i = REG_IMAGE_WIDTH;
  logic [DimW-1:0] cfg_data_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [PixW-1:0] pixel_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [PixW-1:0] mean_value_o;
  logic            row_end_o;
  logic            frame_end_o;

  int pending_results;
  int error_count;
  int stall_cycles = 0;
  bit steady_flow = 1'b0;

  box_blur_3x3 DUT (.*);

  box_blur_3x3_monitor u_monitor (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_i   (in_ready_o),
    .pixel_i,
    .out_valid_i  (out_valid_o),
    .out_ready_i,
    .mean_value_i (mean_value_o),
    .row_end_i    (row_end_o),
    .frame_end_i  (frame_end_o),
    .pending_o    (pending_results),
    .errors_o     (error_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == StallLimit) begin
      $display("tb_box_blur_3x3: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [PixW-1:0] make_pixel(pixel_pattern_e pat, logic [PixW-1:0] level);
    case (pat)
      PAT_EXTREME: return $urandom_range(0, 1) ? 8'hff : 8'h00;
      PAT_BRIGHT: return PixW'($urandom_range(240, 255));
      PAT_FLAT: return level;
      PAT_DARK: return PixW'($urandom_range(0, 15));
      default: return PixW'($urandom_range(0, 255));
    endcase
  endfunction

  // The receiver stalls in bursts of random length once reset is released.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  end

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  task automatic set_dims(logic [DimW-1:0] w_val, logic [DimW-1:0] h_val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_IMAGE_WIDTH;
    cfg_data_i <= w_val;
    @(posedge clk_i);
    cfg_index_i <= REG_IMAGE_HEIGHT;
    cfg_data_i <= h_val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Now and then the sender holds off until every pending result has drained.
  task automatic send_pixel(logic [PixW-1:0] px);
    int gap;
    bit pause;
    gap = pick_gap();
    pause = ($urandom_range(0, 299) == 0);
    if (pause && gap == 0) gap = 1;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      while (pause && pending_results != 0) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i <= px;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [DimW-1:0] w_val, logic [DimW-1:0] h_val,
                           int w, int h, int frames);
    pixel_pattern_e  pat;
    logic [PixW-1:0] level;
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    set_dims(w_val, h_val);
    for (int f = 0; f < frames; f++) begin
      pat = pixel_pattern_e'($urandom_range(0, 4));
      level = PixW'($urandom_range(0, 255));
      for (int k = 0; k < w * h; k++) send_pixel(make_pixel(pat, level));
    end
  endtask

  initial begin
    int w;
    int h;
    int frames;
    int random_px;
    logic [DimW-1:0] w_val;
    logic [DimW-1:0] h_val;
    random_px = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers below the minimum give a 3x3 frame with a single result.
    set_dims(DimW'(0), DimW'(2));
    for (int k = 0; k < 9; k++) send_pixel(8'hff);
    for (int k = 0; k < 9; k++) send_pixel(8'h00);
    for (int k = 0; k < 9; k++) send_pixel(k == 0 ? 8'hfe : 8'hff);

    while (random_px < RandomPixels) begin
      w = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40) : $urandom_range(3, 16);
      h = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 16) : $urandom_range(3, 8);
      w_val = DimW'(w);
      h_val = DimW'(h);
      if ($urandom_range(0, 9) == 0) begin
        w = 3;
        w_val = DimW'($urandom_range(0, 2));
      end
      if ($urandom_range(0, 9) == 0) begin
        h = 3;
        h_val = DimW'($urandom_range(0, 2));
      end
      frames = (w * h > 200) ? 1 : $urandom_range(1, 3);
      steady_flow = ($urandom_range(0, 3) == 0);
      run_phase(w_val, h_val, w, h, frames);
      random_px += w * h * frames;
    end

    steady_flow = 1'b0;

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_box_blur_3x3: done, clean");
    end else begin
      $display("tb_box_blur_3x3: done, errors");
    end
    $finish;
  end

endmodule
